[hw/rtl/dtce_pkg.sv]
// ----------------------------------------------------------------------------
// dtce_pkg
// Types, constants and small helper functions for the date and time check
// and BCD encode block.
// ----------------------------------------------------------------------------
package dtce_pkg;

  localparam int unsigned YearMin = 2000;
  localparam int unsigned YearMax = 2099;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthDec = 4'd12;

  localparam logic [2:0] WeekdayMax = 3'd6;
  localparam logic [4:0] HourMax    = 5'd23;
  localparam logic [5:0] MinSecMax  = 6'd59;

  // One result item as it leaves the encoder.
  typedef struct packed {
    logic       status;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [2:0] weekday_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } dtce_result_t;

  // Two-digit BCD of a value below 100. The tens digit comes from a
  // multiplication by the reciprocal of ten, which is exact in this range.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  // Length of a month in days; zero for a month code that means nothing.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   return 5'd30;
      4'd2:                                      return leap ? 5'd29 : 5'd28;
      default:                                   return 5'd0;
    endcase
  endfunction

  // Month term of Zeller's congruence, floor(13 * (m + 1) / 5) modulo 7,
  // where January and February count as months 13 and 14.
  function automatic logic [2:0] zeller_month(input logic [3:0] m);
    case (m)
      4'd1:    return 3'd1;
      4'd2:    return 3'd4;
      4'd3:    return 3'd3;
      4'd4:    return 3'd6;
      4'd5:    return 3'd1;
      4'd6:    return 3'd4;
      4'd7:    return 3'd6;
      4'd8:    return 3'd2;
      4'd9:    return 3'd5;
      4'd10:   return 3'd0;
      4'd11:   return 3'd3;
      4'd12:   return 3'd5;
      default: return 3'd0;
    endcase
  endfunction

  // Remainder by 7 of an 8-bit value by folding: 64 and 8 are both 1 mod 7.
  function automatic logic [2:0] mod7(input logic [7:0] s);
    logic [6:0] t1;
    logic [3:0] t2;
    logic [3:0] t3;
    t1 = 7'(s[7:6]) + 7'(s[5:0]);
    t2 = 4'(t1[6:3]) + 4'(t1[2:0]);
    t3 = 4'(t2[3]) + 4'(t2[2:0]);
    return (t3 >= 4'd7) ? 3'(t3 - 4'd7) : t3[2:0];
  endfunction

endpackage

[hw/rtl/dtce_encode.sv]
// ----------------------------------------------------------------------------
// dtce_encode
// Combinational check of one date and time and its BCD encoding, with the
// weekday recomputed from the date.
// ----------------------------------------------------------------------------
module dtce_encode (
  input  logic [11:0]                year_value,
  input  logic [3:0]                 month_value,
  input  logic [4:0]                 day_value,
  input  logic [2:0]                 weekday_value,
  input  logic [4:0]                 hour_value,
  input  logic [5:0]                 minute_value,
  input  logic [5:0]                 second_value,
  output dtce_pkg::dtce_result_t     result
);
  import dtce_pkg::*;

  logic       year_ok;
  logic [6:0] yy;
  logic       leap;
  logic       early;
  logic [6:0] k;
  logic       j_term;
  logic [7:0] zsum;
  logic [2:0] h;
  logic       ok;

  always_comb begin
    year_ok = (year_value >= 12'(YearMin)) && (year_value <= 12'(YearMax));
    yy      = 7'(year_value - 12'(YearMin));
    // Every year from 2000 to 2099 divisible by four is a leap year.
    leap    = (yy[1:0] == 2'b00);

    // January and February belong to the previous year in Zeller's form.
    early = (month_value == MonthJan) || (month_value == MonthFeb);
    if (early && (yy == 7'd0)) begin
      k      = 7'd99;
      j_term = 1'b1;   // century 19: 19 / 4 + 5 * 19 is 1 mod 7
    end else begin
      k      = early ? (yy - 7'd1) : yy;
      j_term = 1'b0;   // century 20: 20 / 4 + 5 * 20 is 0 mod 7
    end

    zsum = 8'(day_value) + 8'(zeller_month(month_value)) + 8'(k) + 8'(k[6:2])
         + 8'(j_term);
    h    = mod7(zsum);

    ok = year_ok
      && (month_value >= MonthJan) && (month_value <= MonthDec)
      && (day_value != 5'd0) && (day_value <= month_len(month_value, leap))
      && (weekday_value <= WeekdayMax)
      && (hour_value <= HourMax)
      && (minute_value <= MinSecMax)
      && (second_value <= MinSecMax);

    result = '0;
    if (ok) begin
      result.status      = 1'b0;
      result.second_bcd  = to_bcd(7'(second_value));
      result.minute_bcd  = to_bcd(7'(minute_value));
      result.hour_bcd    = to_bcd(7'(hour_value));
      result.day_bcd     = to_bcd(7'(day_value));
      // Zeller gives 0 for Saturday; shift so that 0 is Sunday.
      result.weekday_bcd = (h == 3'd0) ? 3'd6 : (h - 3'd1);
      result.month_bcd   = to_bcd(7'(month_value));
      result.year_bcd    = to_bcd(yy);
    end else begin
      result.status = 1'b1;
    end
  end

endmodule

[hw/rtl/datetime_check_bcd_encode.sv]
// ----------------------------------------------------------------------------
// datetime_check_bcd_encode
// Checks a decimal date and time and encodes it as BCD clock register bytes.
// An accepted item passes through the input register, then the result register,
// where it waits until the consumer takes it.
// Throughput: one item per cycle while the consumer does not stall; the check
// and encode logic between the two registers is a single combinational pass.
// Reset: synchronous, active high; it empties both registers.
// ----------------------------------------------------------------------------
module datetime_check_bcd_encode (
  input  logic        clk,
  input  logic        rst,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] year_value,
  input  logic [3:0]  month_value,
  input  logic [4:0]  day_value,
  input  logic [2:0]  weekday_value,
  input  logic [4:0]  hour_value,
  input  logic [5:0]  minute_value,
  input  logic [5:0]  second_value,
  // Output channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [7:0]  second_bcd,
  output logic [7:0]  minute_bcd,
  output logic [7:0]  hour_bcd,
  output logic [7:0]  day_bcd,
  output logic [2:0]  weekday_bcd,
  output logic [7:0]  month_bcd,
  output logic [7:0]  year_bcd
);
  import dtce_pkg::*;

  // Input register: holds the accepted item while the encoder works on it.
  logic        in_full;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [2:0]  weekday_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;

  // Result register: a finished item waits here until the consumer takes it.
  logic         out_full;
  dtce_result_t result_r;
  dtce_result_t result_next;

  logic out_take;
  logic in_take;

  // The result register can load when it is empty or is emptied this cycle.
  // The input register can load when it is empty or moves on this cycle, so
  // an item enters every cycle as long as the consumer keeps up.
  assign out_take = !out_full || !out_stall;
  assign in_stall = in_full && !out_take;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (out_take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      year_r    <= year_value;
      month_r   <= month_value;
      day_r     <= day_value;
      weekday_r <= weekday_value;
      hour_r    <= hour_value;
      minute_r  <= minute_value;
      second_r  <= second_value;
    end
  end

  // All checking and encoding for the item in the input register.
  dtce_encode u_encode (
    .year_value    (year_r),
    .month_value   (month_r),
    .day_value     (day_r),
    .weekday_value (weekday_r),
    .hour_value    (hour_r),
    .minute_value  (minute_r),
    .second_value  (second_r),
    .result        (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_take) begin
      out_full <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && in_full) begin
      result_r <= result_next;
    end
  end

  assign out_valid   = out_full;
  assign status      = result_r.status;
  assign second_bcd  = result_r.second_bcd;
  assign minute_bcd  = result_r.minute_bcd;
  assign hour_bcd    = result_r.hour_bcd;
  assign day_bcd     = result_r.day_bcd;
  assign weekday_bcd = result_r.weekday_bcd;
  assign month_bcd   = result_r.month_bcd;
  assign year_bcd    = result_r.year_bcd;

endmodule
